[hdl/look_at_view_matrix_assert.svh]
// assertion macros for the rtl top, clocked on clk and quiet in reset
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// plain property check
`define LVM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define LVM_ASSERT_IMPL(lbl, ante, cons, msg) \
	`LVM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[hdl/lvm_pkg.sv]
package lvm_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int WORD_BITS  = 32;
	localparam int ROT_BITS   = FRAC_BITS + 2;
	localparam int NORM_LO    = 29;
	localparam int SC_W       = NORM_LO + 1;
	localparam int VEC_W      = 49;
	localparam int MAG_W      = VEC_W;
	localparam int POS_W      = 6;
	localparam int SQ_W       = 2 * SC_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int SQRT_STEPS = SUM_W / 2;
	localparam int ROOT_W     = SQRT_STEPS;
	localparam int SQX_W      = SUM_W + 2;
	localparam int DIV_STEPS  = FRAC_BITS + 1;
	localparam int NUM_W      = ROOT_W + DIV_STEPS;
	// input regs, msb position, scale, square, sum, root steps, divide steps, sign stage
	localparam int NORM_LAT   = 5 + SQRT_STEPS + DIV_STEPS + 1;

	// register indexes of the apb port, byte address is 4 * index
	localparam logic [1:0] REG_UP_X = 2'd0;
	localparam logic [1:0] REG_UP_Y = 2'd1;
	localparam logic [1:0] REG_UP_Z = 2'd2;

	typedef logic signed [VEC_W-1:0]     vec_t;
	typedef logic signed [ROT_BITS-1:0]  rot_t;
	typedef logic signed [WORD_BITS-1:0] word_t;

	// index of the highest set bit, zero for an all-zero word
	function automatic logic [POS_W-1:0] msb_pos(input logic [MAG_W-1:0] v);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (v[i]) p = POS_W'(i);
		end
		return p;
	endfunction

	// move the top bit to position NORM_LO, truncating on the way down
	function automatic logic [SC_W-1:0] scale_mag(input logic [MAG_W-1:0] m,
		input logic [POS_W-1:0] p);
		logic [MAG_W+NORM_LO-1:0] w;
		w = {m, {NORM_LO{1'b0}}} >> p;
		return w[SC_W-1:0];
	endfunction

endpackage

[hdl/look_at_view_matrix.sv]
// look-at view matrix unit, signed fixed point q16.16
// input stream (s_tvalid/s_tready/s_tdata): one word per camera holding eye and
// target points; a word is taken on any edge with tvalid and tready high.
// output stream (m_tvalid/m_tready/m_tdata): one word per input word, in order,
// holding the nine rotation entries (right, true up and back axes) and the
// three saturated translation entries.
// apb port: up_x, up_y, up_z at byte addresses 0, 4, 8; write them only while
// the pipeline is empty. pready is tied high, reads return the register.
// throughput is one word per cycle while the receiver does not stall. the
// two normalizers stand in series, each a 31-step square root pipeline
// followed by a 17-step divider pipeline (54 stages counting input and sign stages).
// the configured up vector is pre-scaled in three free-running registers.
// reset clears the pipeline valid bits and loads up = (0, 1.0, 0).
// when the receiver stalls with a word waiting at the output, the whole
// pipeline freezes and s_tready drops in the same cycle; bubbles in flight
// are not squeezed out. nothing is dropped or repeated.
module look_at_view_matrix (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// eye_x, eye_y, eye_z, target_x, target_y, target_z (32 bits each)
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// xaxis_x, yaxis_x, zaxis_x, xaxis_y, yaxis_y, zaxis_y, xaxis_z, yaxis_z,
	// zaxis_z (18 bits each), trans_x, trans_y, trans_z (32 bits each), 6 pad
	output logic [263:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	`include "look_at_view_matrix_assert.svh"

	localparam int FB    = lvm_pkg::FRAC_BITS;
	localparam int WB    = lvm_pkg::WORD_BITS;
	localparam int RB    = lvm_pkg::ROT_BITS;
	localparam int SC_W  = lvm_pkg::SC_W;
	localparam int MAG_W = lvm_pkg::MAG_W;
	localparam int NL    = lvm_pkg::NORM_LAT;

	// stage numbers, counted in edges after the input edge
	localparam int P1    = 1 + NL;      // back axis out of first normalizer
	localparam int X2    = P1 + 2;      // cross(up, back) ready
	localparam int P2    = X2 + NL;     // right axis out of second normalizer
	localparam int Y3    = P2 + 3;      // true up axis ready
	localparam int NSTG  = Y3 + 3;      // output register
	localparam int EYE_D = Y3;
	localparam int BK_D  = Y3 - P1;
	localparam int RT_D  = Y3 - P2;

	localparam int YP_W  = 2 * RB;
	localparam int YC_W  = YP_W + 1;
	localparam int ZP_W  = RB + WB;
	localparam int ZS_W  = ZP_W + 2;
	localparam int TT_W  = ZS_W - FB + 2;

	localparam lvm_pkg::rot_t ROT_ONE = lvm_pkg::rot_t'(1 << FB);
	localparam longint T_MAX = (longint'(1) <<< (WB - 1)) - 1;
	localparam longint T_MIN = -(longint'(1) <<< (WB - 1));

	typedef logic signed [SC_W:0] ups_t;

	// shift out FRAC_BITS rounding half away from zero, clamp to one
	function automatic lvm_pkg::rot_t round_clamp(input logic signed [YC_W-1:0] v);
		logic [YC_W-1:0] m;
		logic [YC_W-1:0] r;
		m = v[YC_W-1] ? YC_W'(-v) : YC_W'(v);
		r = (m + YC_W'(1 << (FB - 1))) >> FB;
		if (r > YC_W'(1 << FB)) r = YC_W'(1 << FB);
		return v[YC_W-1] ? -lvm_pkg::rot_t'(r) : lvm_pkg::rot_t'(r);
	endfunction

	// negate, round to nearest with ties up, saturate to a word
	function automatic lvm_pkg::word_t trans_sat(input logic signed [ZS_W-1:0] s);
		logic signed [ZS_W-FB-1:0] fl;
		logic signed [TT_W-1:0]    t;
		logic                      rup;
		fl  = s[ZS_W-1:FB];
		rup = s[FB-1:0] > FB'(1 << (FB - 1));
		t   = -(TT_W'(fl) + TT_W'(rup));
		if (t > TT_W'(T_MAX)) return lvm_pkg::word_t'(T_MAX);
		if (t < TT_W'(T_MIN)) return lvm_pkg::word_t'(T_MIN);
		return lvm_pkg::word_t'(t);
	endfunction

	logic                adv;
	logic [NSTG-1:0]     vld_q;

	// configuration
	lvm_pkg::word_t      up_q [3];
	logic [MAG_W-1:0]    upm_q [3];
	logic [2:0]          upn_q;
	logic [lvm_pkg::POS_W-1:0] uppos_q;
	ups_t                ups_q [3];

	lvm_pkg::word_t      in_eye [3];
	lvm_pkg::word_t      in_tgt [3];
	lvm_pkg::vec_t       diff_s1 [3];
	lvm_pkg::word_t      eye_sk [EYE_D][3];
	lvm_pkg::rot_t       back_n [3];
	lvm_pkg::rot_t       bk_sk [BK_D][3];
	logic signed [lvm_pkg::VEC_W-1:0] xp_sx1 [6];
	lvm_pkg::vec_t       tmp_sx2 [3];
	lvm_pkg::rot_t       right_n [3];
	lvm_pkg::rot_t       rt_sk [RT_D][3];
	logic signed [YP_W-1:0] yp_sy1 [6];
	logic signed [YC_W-1:0] yc_sy2 [3];
	lvm_pkg::rot_t       tup_sy3 [3];
	logic signed [ZP_W-1:0] zp_sz1 [3][3];
	lvm_pkg::rot_t       rot_sz1 [9];
	logic signed [ZS_W-1:0] zs_sz2 [3];
	lvm_pkg::rot_t       rot_sz2 [9];
	lvm_pkg::word_t      trans_sz3 [3];
	lvm_pkg::rot_t       rot_sz3 [9];

	// the pipeline moves whenever the output word is free or being taken
	assign adv      = !vld_q[NSTG-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[NSTG-1];
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], s_tvalid};
		end
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q[0] <= '0;
			up_q[1] <= lvm_pkg::word_t'(1 << FB);
			up_q[2] <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				lvm_pkg::REG_UP_X: up_q[0] <= pwdata;
				lvm_pkg::REG_UP_Y: up_q[1] <= pwdata;
				lvm_pkg::REG_UP_Z: up_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lvm_pkg::REG_UP_X: prdata = up_q[0];
			lvm_pkg::REG_UP_Y: prdata = up_q[1];
			lvm_pkg::REG_UP_Z: prdata = up_q[2];
			default:  prdata = '0;
		endcase
	end

	// up vector scaled to a top magnitude in [2^29, 2^30), free running
	// magnitude taken at full width so that the most negative word gives 2^31
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			upn_q[i] <= up_q[i][WB-1];
			upm_q[i] <= up_q[i][WB-1] ? MAG_W'(-lvm_pkg::vec_t'(up_q[i]))
				: MAG_W'(lvm_pkg::vec_t'(up_q[i]));
			ups_q[i] <= upn_q[i] ? -ups_t'({1'b0, lvm_pkg::scale_mag(upm_q[i], uppos_q)})
				: ups_t'({1'b0, lvm_pkg::scale_mag(upm_q[i], uppos_q)});
		end
		uppos_q <= lvm_pkg::msb_pos(upm_q[0] | upm_q[1] | upm_q[2]);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_eye[i] = s_tdata[WB*i +: WB];
			in_tgt[i] = s_tdata[WB*(i+3) +: WB];
		end
	end

	// back axis: normalize(eye - target)
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				diff_s1[i] <= lvm_pkg::vec_t'(in_eye[i]) - lvm_pkg::vec_t'(in_tgt[i]);
			end
			eye_sk[0] <= in_eye;
			for (int k = 1; k < EYE_D; k++) eye_sk[k] <= eye_sk[k-1];
		end
	end

	lvm_norm u_norm_back (
		.clk (clk),
		.en  (adv),
		.vec (diff_s1),
		.nrm (back_n)
	);

	// right axis: normalize(cross(up, back))
	always_ff @(posedge clk) begin
		if (adv) begin
			xp_sx1[0] <= ups_q[1] * back_n[2];
			xp_sx1[1] <= ups_q[2] * back_n[1];
			xp_sx1[2] <= ups_q[2] * back_n[0];
			xp_sx1[3] <= ups_q[0] * back_n[2];
			xp_sx1[4] <= ups_q[0] * back_n[1];
			xp_sx1[5] <= ups_q[1] * back_n[0];
			tmp_sx2[0] <= xp_sx1[0] - xp_sx1[1];
			tmp_sx2[1] <= xp_sx1[2] - xp_sx1[3];
			tmp_sx2[2] <= xp_sx1[4] - xp_sx1[5];
			bk_sk[0] <= back_n;
			for (int k = 1; k < BK_D; k++) bk_sk[k] <= bk_sk[k-1];
		end
	end

	lvm_norm u_norm_right (
		.clk (clk),
		.en  (adv),
		.vec (tmp_sx2),
		.nrm (right_n)
	);

	// true up axis: cross(back, right) with rounding and clamp
	always_ff @(posedge clk) begin
		if (adv) begin
			yp_sy1[0] <= bk_sk[P2-P1-1][1] * right_n[2];
			yp_sy1[1] <= bk_sk[P2-P1-1][2] * right_n[1];
			yp_sy1[2] <= bk_sk[P2-P1-1][2] * right_n[0];
			yp_sy1[3] <= bk_sk[P2-P1-1][0] * right_n[2];
			yp_sy1[4] <= bk_sk[P2-P1-1][0] * right_n[1];
			yp_sy1[5] <= bk_sk[P2-P1-1][1] * right_n[0];
			yc_sy2[0] <= yp_sy1[0] - yp_sy1[1];
			yc_sy2[1] <= yp_sy1[2] - yp_sy1[3];
			yc_sy2[2] <= yp_sy1[4] - yp_sy1[5];
			for (int i = 0; i < 3; i++) tup_sy3[i] <= round_clamp(yc_sy2[i]);
			rt_sk[0] <= right_n;
			for (int k = 1; k < RT_D; k++) rt_sk[k] <= rt_sk[k-1];
		end
	end

	// translations: exact dot with the eye, then negate, round and saturate
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				zp_sz1[0][i] <= rt_sk[RT_D-1][i] * eye_sk[EYE_D-1][i];
				zp_sz1[1][i] <= tup_sy3[i] * eye_sk[EYE_D-1][i];
				zp_sz1[2][i] <= bk_sk[BK_D-1][i] * eye_sk[EYE_D-1][i];
				rot_sz1[3*i]     <= rt_sk[RT_D-1][i];
				rot_sz1[3*i + 1] <= tup_sy3[i];
				rot_sz1[3*i + 2] <= bk_sk[BK_D-1][i];
			end
			for (int a = 0; a < 3; a++) begin
				zs_sz2[a] <= ZS_W'(zp_sz1[a][0]) + ZS_W'(zp_sz1[a][1])
					+ ZS_W'(zp_sz1[a][2]);
				trans_sz3[a] <= trans_sat(zs_sz2[a]);
			end
			rot_sz2 <= rot_sz1;
			rot_sz3 <= rot_sz2;
		end
	end

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < 9; i++) m_tdata[RB*i +: RB] = rot_sz3[i];
		for (int a = 0; a < 3; a++) m_tdata[9*RB + WB*a +: WB] = trans_sz3[a];
	end

	`LVM_ASSERT_IMPL(a_rot_range, m_tvalid, (rot_sz3[0] <= ROT_ONE) && (rot_sz3[0] >= -ROT_ONE), "right x beyond one")
	`LVM_ASSERT_IMPL(a_back_zero_trans, m_tvalid && (rot_sz3[2] == '0) && (rot_sz3[5] == '0) && (rot_sz3[8] == '0), trans_sz3[2] == '0, "zero back axis with nonzero translation")
	`LVM_ASSERT_IMPL(a_right_zero_up, m_tvalid && (rot_sz3[0] == '0) && (rot_sz3[3] == '0) && (rot_sz3[6] == '0), (rot_sz3[1] == '0) && (rot_sz3[4] == '0) && (rot_sz3[7] == '0) && (trans_sz3[0] == '0), "zero right axis with nonzero up or translation")

endmodule

[hdl/lvm_norm.sv]
module lvm_norm (
	input  logic            clk,
	input  logic            en,
	input  lvm_pkg::vec_t   vec [3],
	output lvm_pkg::rot_t   nrm [3]
);

	localparam int MAG_W  = lvm_pkg::MAG_W;
	localparam int SC_W   = lvm_pkg::SC_W;
	localparam int SQ_W   = lvm_pkg::SQ_W;
	localparam int SUM_W  = lvm_pkg::SUM_W;
	localparam int SQX_W  = lvm_pkg::SQX_W;
	localparam int NSQ    = lvm_pkg::SQRT_STEPS;
	localparam int NDV    = lvm_pkg::DIV_STEPS;
	localparam int NUM_W  = lvm_pkg::NUM_W;
	localparam int ROOT_W = lvm_pkg::ROOT_W;
	localparam int VEC_W  = lvm_pkg::VEC_W;
	localparam int FB     = lvm_pkg::FRAC_BITS;

	logic [MAG_W-1:0]           mag_s1 [3];
	logic [2:0]                 neg_s1;
	logic [MAG_W-1:0]           or_s1;
	logic [MAG_W-1:0]           mag_s2 [3];
	logic [2:0]                 neg_s2;
	logic [lvm_pkg::POS_W-1:0]  pos_s2;
	logic                       zero_s2;
	logic [SC_W-1:0]            sc_s3 [3];
	logic [2:0]                 neg_s3;
	logic                       zero_s3;
	logic [SQ_W-1:0]            sq_s4 [3];
	logic [SC_W-1:0]            sc_s4 [3];
	logic [2:0]                 neg_s4;
	logic                       zero_s4;
	logic [SUM_W-1:0]           sum_s5;
	logic [SC_W-1:0]            sc_s5 [3];
	logic [2:0]                 neg_s5;
	logic                       zero_s5;

	// root steps, one result bit each
	logic [SQX_W-1:0]           rx_sk [NSQ];
	logic [SQX_W-1:0]           rr_sk [NSQ];
	logic [SC_W-1:0]            rsc_sk [NSQ][3];
	logic [2:0]                 rneg_sk [NSQ];
	logic                       rzero_sk [NSQ];

	// divide steps, one quotient bit each
	logic [NUM_W-1:0]           drem_sk [NDV][3];
	logic [NDV-1:0]             dq_sk [NDV][3];
	logic [ROOT_W-1:0]          dlen_sk [NDV];
	logic [2:0]                 dneg_sk [NDV];
	logic                       dzero_sk [NDV];

	lvm_pkg::rot_t              res_slast [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][VEC_W-1];
				mag_s1[i] <= vec[i][VEC_W-1] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
			end
			or_s1 <= MAG_W'(vec[0][VEC_W-1] ? -vec[0] : vec[0])
				| MAG_W'(vec[1][VEC_W-1] ? -vec[1] : vec[1])
				| MAG_W'(vec[2][VEC_W-1] ? -vec[2] : vec[2]);

			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			pos_s2  <= lvm_pkg::msb_pos(or_s1);
			zero_s2 <= (or_s1 == '0);

			for (int i = 0; i < 3; i++) begin
				sc_s3[i] <= lvm_pkg::scale_mag(mag_s2[i], pos_s2);
			end
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;

			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= SQ_W'(sc_s3[i]) * SQ_W'(sc_s3[i]);
			end
			sc_s4   <= sc_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;

			sum_s5  <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			sc_s5   <= sc_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;

			rsc_sk[0]   <= sc_s5;
			rneg_sk[0]  <= neg_s5;
			rzero_sk[0] <= zero_s5;
			for (int k = 1; k < NSQ; k++) begin
				rsc_sk[k]   <= rsc_sk[k-1];
				rneg_sk[k]  <= rneg_sk[k-1];
				rzero_sk[k] <= rzero_sk[k-1];
			end

			dlen_sk[0]  <= rr_sk[NSQ-1][ROOT_W-1:0];
			dneg_sk[0]  <= rneg_sk[NSQ-1];
			dzero_sk[0] <= rzero_sk[NSQ-1];
			for (int k = 1; k < NDV; k++) begin
				dlen_sk[k]  <= dlen_sk[k-1];
				dneg_sk[k]  <= dneg_sk[k-1];
				dzero_sk[k] <= dzero_sk[k-1];
			end

			for (int i = 0; i < 3; i++) begin
				if (dzero_sk[NDV-1]) begin
					res_slast[i] <= '0;
				end else if (dneg_sk[NDV-1][i]) begin
					res_slast[i] <= -lvm_pkg::rot_t'({1'b0, dq_sk[NDV-1][i]});
				end else begin
					res_slast[i] <= lvm_pkg::rot_t'({1'b0, dq_sk[NDV-1][i]});
				end
			end
		end
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_root
		localparam logic [SQX_W-1:0] BIT = SQX_W'(1) << (2 * (NSQ - 1 - k));
		logic [SQX_W-1:0] x_in, r_in, trial;
		if (k == 0) begin : g_first
			assign x_in = SQX_W'(sum_s5);
			assign r_in = '0;
		end else begin : g_next
			assign x_in = rx_sk[k-1];
			assign r_in = rr_sk[k-1];
		end
		assign trial = r_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (x_in >= trial) begin
					rx_sk[k] <= x_in - trial;
					rr_sk[k] <= (r_in >> 1) + BIT;
				end else begin
					rx_sk[k] <= x_in;
					rr_sk[k] <= r_in >> 1;
				end
			end
		end
	end

	// quotient bits from the top; numerator carries the half-divisor rounding term
	for (genvar j = 0; j < NDV; j++) begin : g_div
		localparam int SH = NDV - 1 - j;
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [NUM_W-1:0] rem_in, den;
			logic [NDV-1:0]   q_in;
			if (j == 0) begin : g_first
				logic [ROOT_W-1:0] len0;
				assign len0   = rr_sk[NSQ-1][ROOT_W-1:0];
				assign rem_in = (NUM_W'(rsc_sk[NSQ-1][l]) << FB) + NUM_W'(len0 >> 1);
				assign den    = NUM_W'(len0) << SH;
				assign q_in   = '0;
			end else begin : g_next
				assign rem_in = drem_sk[j-1][l];
				assign den    = NUM_W'(dlen_sk[j-1]) << SH;
				assign q_in   = dq_sk[j-1][l];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					if (rem_in >= den) begin
						drem_sk[j][l] <= rem_in - den;
						dq_sk[j][l]   <= q_in | (NDV'(1) << SH);
					end else begin
						drem_sk[j][l] <= rem_in;
						dq_sk[j][l]   <= q_in;
					end
				end
			end
		end
	end

	assign nrm = res_slast;

endmodule

[dv/look_at_view_matrix_test.sv]
module look_at_view_matrix_test;

	timeunit 1ns;
	timeprecision 1ps;

	typedef longint vec3_t [3];

	// one camera: eye and target points
	typedef struct {
		logic [31:0] eye [3];
		logic [31:0] target [3];
	} camera_t;

	// one view matrix result in output word order
	typedef struct {
		lvm_pkg::rot_t  rot [9];
		lvm_pkg::word_t trans [3];
	} view_t;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_WAIT = 150;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// eye_x, eye_y, eye_z, target_x, target_y, target_z (32 bits each)
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// xaxis_x, yaxis_x, zaxis_x, xaxis_y, yaxis_y, zaxis_y, xaxis_z, yaxis_z,
	// zaxis_z (18 bits each), trans_x, trans_y, trans_z (32 bits each), pad
	logic [263:0] m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	look_at_view_matrix i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cameras waiting to be driven and view matrices waiting to come out
	camera_t camera_q [$];
	view_t   view_q [$];

	// up vector as the block holds it
	longint  up_vec [3] = '{0, 65536, 0};

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  camera_taken = 1'b0;
	int  errors = 0;
	int  quiet_cycles = 0;

	string field_name [12] = '{"xaxis_x", "yaxis_x", "zaxis_x", "xaxis_y", "yaxis_y",
		"zaxis_y", "xaxis_z", "yaxis_z", "zaxis_z", "trans_x", "trans_y", "trans_z"};

	function automatic longint unsigned abs_of(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	// power-of-two scaling of the largest magnitude into [2^29, 2^30)
	function automatic vec3_t scale_pow2(vec3_t v);
		vec3_t o;
		longint unsigned m [3];
		longint unsigned top;
		int dn, upc;
		top = 0;
		dn = 0;
		upc = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = abs_of(v[i]);
			if (m[i] > top) top = m[i];
		end
		if (top == 0) begin
			o = '{0, 0, 0};
			return o;
		end
		while (top >= (64'd1 << 30)) begin
			top = top >> 1;
			dn++;
		end
		while (top < (64'd1 << 29)) begin
			top = top << 1;
			upc++;
		end
		for (int i = 0; i < 3; i++) begin
			o[i] = longint'((m[i] >> dn) << upc);
			if (v[i] < 0) o[i] = -o[i];
		end
		return o;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// unit vector, zero-length stays zero
	function automatic vec3_t unit_of(vec3_t v);
		vec3_t s, n;
		longint unsigned sum, len, q;
		s = scale_pow2(v);
		sum = 0;
		for (int i = 0; i < 3; i++) sum += abs_of(s[i]) * abs_of(s[i]);
		n = '{0, 0, 0};
		if (sum == 0) return n;
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((abs_of(s[i]) << lvm_pkg::FRAC_BITS) + (len >> 1)) / len;
			n[i] = s[i] < 0 ? -longint'(q) : longint'(q);
		end
		return n;
	endfunction

	function automatic vec3_t cross_of(vec3_t a, vec3_t b);
		vec3_t c;
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		return c;
	endfunction

	// minus dot(axis, eye), round to nearest with ties up, saturate
	function automatic longint eye_offset(vec3_t a, vec3_t e);
		longint d, h, l, eh, el, ql, rl, t;
		d = longint'(1) << lvm_pkg::FRAC_BITS;
		h = 0;
		l = 0;
		for (int i = 0; i < 3; i++) begin
			eh = e[i] / d;
			el = e[i] % d;
			if (el < 0) begin
				el += d;
				eh -= 1;
			end
			h += a[i] * eh;
			l += a[i] * el;
		end
		ql = l / d;
		rl = l % d;
		if (rl < 0) begin
			rl += d;
			ql -= 1;
		end
		t = -(h + ql) - ((rl > d / 2) ? 1 : 0);
		if (t > 64'sd2147483647) t = 64'sd2147483647;
		if (t < -64'sd2147483648) t = -64'sd2147483648;
		return t;
	endfunction

	function automatic view_t predict_view(camera_t c);
		view_t r;
		vec3_t eye, diff, back, right, tup, tmp;
		longint unsigned m, one;
		one = 64'd1 << lvm_pkg::FRAC_BITS;
		for (int i = 0; i < 3; i++) begin
			eye[i] = longint'($signed(c.eye[i]));
			diff[i] = eye[i] - longint'($signed(c.target[i]));
		end
		back = unit_of(diff);
		right = unit_of(cross_of(scale_pow2(up_vec), back));
		tmp = cross_of(back, right);
		// true up: shift with rounding half away from zero, clamp to one
		for (int i = 0; i < 3; i++) begin
			m = (abs_of(tmp[i]) + (one >> 1)) >> lvm_pkg::FRAC_BITS;
			if (m > one) m = one;
			tup[i] = tmp[i] < 0 ? -longint'(m) : longint'(m);
		end
		for (int i = 0; i < 3; i++) begin
			r.rot[i*3 + 0] = lvm_pkg::rot_t'(right[i]);
			r.rot[i*3 + 1] = lvm_pkg::rot_t'(tup[i]);
			r.rot[i*3 + 2] = lvm_pkg::rot_t'(back[i]);
		end
		r.trans[0] = lvm_pkg::word_t'(eye_offset(right, eye));
		r.trans[1] = lvm_pkg::word_t'(eye_offset(tup, eye));
		r.trans[2] = lvm_pkg::word_t'(eye_offset(back, eye));
		return r;
	endfunction

	// driver: present the next camera word and a random ready on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || camera_taken) begin
				if (camera_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					camera_t c;
					c = camera_q.pop_front();
					s_tdata <= {c.target[2], c.target[1], c.target[0],
						c.eye[2], c.eye[1], c.eye[0]};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on input accept, check on output accept
	always @(posedge clk) begin
		camera_t c;
		view_t got, want;
		bit busy;
		camera_taken <= s_tvalid && s_tready;
		busy = camera_q.size() > 0 || view_q.size() > 0 || s_tvalid;
		if (s_tvalid && s_tready) begin
			for (int i = 0; i < 3; i++) begin
				c.eye[i] = s_tdata[32*i +: 32];
				c.target[i] = s_tdata[96 + 32*i +: 32];
			end
			view_q.push_back(predict_view(c));
		end
		if (m_tvalid && m_tready) begin
			for (int i = 0; i < 9; i++) got.rot[i] = m_tdata[18*i +: 18];
			for (int i = 0; i < 3; i++) got.trans[i] = m_tdata[162 + 32*i +: 32];
			if (view_q.size() == 0) begin
				$display("%0t: result word with none expected, %h", $realtime, m_tdata);
				errors++;
			end else begin
				want = view_q.pop_front();
				for (int i = 0; i < 9; i++) begin
					if (got.rot[i] !== want.rot[i]) begin
						$display("%0t: %s expected %0d actual %0d", $realtime,
							field_name[i], want.rot[i], got.rot[i]);
						errors++;
					end
				end
				for (int i = 0; i < 3; i++) begin
					if (got.trans[i] !== want.trans[i]) begin
						$display("%0t: %s expected %0d actual %0d", $realtime,
							field_name[9 + i], want.trans[i], got.trans[i]);
						errors++;
					end
				end
			end
		end
		// watchdog: no word moving while work is pending
		if (busy && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[look_at_view_matrix] ERROR");
			$finish;
		end
	end

	// apb write, setup then access, falling-edge driven; byte address is 4 * index
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		up_vec[int'(idx)] = longint'($signed(value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_up(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		write_reg(lvm_pkg::REG_UP_X, x);
		write_reg(lvm_pkg::REG_UP_Y, y);
		write_reg(lvm_pkg::REG_UP_Z, z);
	endtask

	task automatic add_camera(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
		logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
		camera_t c;
		c.eye = '{ex, ey, ez};
		c.target = '{tx, ty, tz};
		camera_q.push_back(c);
	endtask

	// small coordinate, within 16 units of the origin
	function automatic logic [31:0] near_value();
		return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
	endfunction

	task automatic add_random(int count);
		logic [31:0] e [3];
		logic [31:0] t [3];
		int kind;
		repeat (count) begin
			kind = $urandom_range(9);
			for (int i = 0; i < 3; i++) begin
				e[i] = $urandom;
				t[i] = $urandom;
			end
			case (kind)
				0, 1, 2: begin
					// scene-sized coordinates
					for (int i = 0; i < 3; i++) begin
						e[i] = near_value();
						t[i] = near_value();
					end
				end
				3: begin
					// target close to eye, tiny back vector
					for (int i = 0; i < 3; i++)
						t[i] = e[i] + 32'($signed($urandom_range(0, 8)) - 4);
				end
				4: begin
					// eye equals target
					t = e;
				end
				5: begin
					// looking along one axis, up may be parallel
					t = e;
					t[$urandom_range(2)] = $urandom;
				end
				default: ;
			endcase
			add_camera(e[0], e[1], e[2], t[0], t[1], t[2]);
		end
	endtask

	// let everything in flight come out before touching registers
	task automatic wait_drained();
		while (camera_q.size() > 0 || s_tvalid || view_q.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	localparam logic [31:0] MAXV = 32'h7fff_ffff;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam logic [31:0] ONE  = 32'h0001_0000;

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part with the reset up vector written back explicitly
		set_up(32'd0, ONE, 32'd0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		add_camera(0, 0, 0, 0, 0, 0);                       // eye equals target
		add_camera(ONE, 0, 0, 0, 0, 0);
		add_camera(0, 0, ONE, 0, 0, 0);
		add_camera(0, 32'd5 << 16, 0, 0, 0, 0);             // back parallel to up
		add_camera(0, 0, 0, 0, ONE, 0);                     // back anti-parallel to up
		add_camera(MAXV, MAXV, MAXV, MINV, MINV, MINV);     // widest difference
		add_camera(MINV, MINV, MINV, MAXV, MAXV, MAXV);
		add_camera(MAXV, MAXV, MAXV, 0, 0, 0);              // translation saturates low
		add_camera(MINV, MINV, MINV, 0, 0, 0);              // translation saturates low
		add_camera(MINV, MAXV, MINV, MAXV, MINV, MAXV);
		add_camera(32'd1, 0, 0, 0, 0, 0);                   // one lsb difference
		add_camera(32'd1, 32'd1, 32'd1, 0, 0, 0);
		add_camera(32'hffff_ffff, 0, 32'd2, 0, 32'd1, 0);
		add_camera(32'd3 << 16, 32'd4 << 16, 32'd5 << 16, 0, 0, 0);
		add_camera(32'h0000_8000, 32'hffff_8000, 32'h0001_8000, 0, 0, 32'd7);
		add_camera(32'h1234_5678, 32'h8765_4321, 32'hdead_beef, 32'h0f0f_0f0f,
			32'hf0f0_f0f0, 32'h5555_aaaa);
		add_camera(MAXV, 0, 0, MAXV - 1, 0, 0);
		add_camera(MINV, MINV, MINV, MINV, MINV, MINV);
		wait_drained();

		// random phases over several up vectors and idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_up(32'd0, ONE, 32'd0);
				1: set_up(ONE, 32'd0, 32'd0);
				2: set_up(MAXV, MINV, MAXV);
				3: set_up(32'd0, 32'd0, 32'd0);              // zero up vector
				4: set_up(MINV, MINV, MINV);
				5: set_up(32'd1, 32'd0, 32'd0);
				6: set_up($urandom, $urandom, $urandom);
				default: set_up(near_value(), near_value(), near_value());
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			add_random(54);
			wait_drained();
		end

		if (errors == 0)
			$display("[look_at_view_matrix] OK");
		else
			$display("[look_at_view_matrix] ERROR");
		$finish;
	end

endmodule
